// ===== rtl/core/efs_pkg.sv =====
// shared types, constants and helpers for the endpoint failover selector
package efs_pkg;

    // list capacity and derived widths
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int CMD_W      = 2;
    localparam int ID_W       = 8;
    localparam int FAIL_W     = 16;
    localparam int ENTRIES_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // stream word layout
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = M_TDATA_W - ID_W - ENTRIES_W;

    // failure count that triggers halving
    localparam logic [FAIL_W-1:0] FAIL_LIMIT = 16'hFFFF;

    // commands
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_FAIL  = 2'd3
    } cmd_t;

    // strategy codes (three acts as round robin)
    localparam logic [1:0] STRAT_LAST_OK = 2'd0;
    localparam logic [1:0] STRAT_LEAST   = 2'd1;
    localparam logic [1:0] STRAT_ROUND   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KIND_FILTER = 2'd1;

    // one list entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [FAIL_W-1:0] fail;
    } entry_t;

    // access request to the entry store
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT_DATA,
        S_SEARCH,
        S_SINK,
        S_PLACE,
        S_HALVE_START,
        S_HALVE,
        S_DONE
    } state_t;

    // cyclic cursor step, wrapping at the list length
    function automatic logic [IDX_W-1:0] cursor_advance(input logic [IDX_W-1:0] from,
                                                         input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] c;
        c = LEN_W'(from) + LEN_W'(1);
        return (c >= len) ? '0 : IDX_W'(c);
    endfunction

endpackage

// ===== rtl/core/efs_entry_store.sv =====
// entry memory: one write port, one read port with registered data
module efs_entry_store
    import efs_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_entry
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered data
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_entry = rd_data_reg;

endmodule

// ===== rtl/core/endpoint_failover_selector_top.sv =====
// endpoint failover selector: command sequencer around the entry store
//
// Commands arrive on the s_ stream, one word each; every command returns
// exactly one word on the m_ stream. Strategy and kind filter are written
// through the cfg channel (always ready); the user must write them only
// while no command is in flight, which the block itself does not enforce.
// The entry list lives in a single-port-read, single-port-write memory with
// a registered read port; all list walks go through that read port.
// Clear and add go from accept straight to the result step; next first
// waits in a data step for the read. A failure report scans the list one
// entry per cycle, under least-failures-first shifts the entry back one slot
// per cycle, and when a count hits the limit halves every count in a further
// pass after a setup step, before its result step.
// One command is worked on at a time; s_tready is high only when the
// sequencer is idle, and a finished result sits in the output register so
// the next command is taken while the receiver stalls the previous word.
// A stalled receiver holds the block at its result step after that.
// Reset (aresetn low, synchronous) empties the list, zeroes the cursor and
// both registers, and drops any pending result. No memory clearing is done.
module endpoint_failover_selector_top
    import efs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // command[1:0], entry_id[9:2], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // is_secure[0], is_plain[1]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // chosen_id[7:0], entries_held[12:8], zero pad
    output logic [M_TUSER_W-1:0]  m_tuser,   // valid_res[0]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [1:0]           strategy_reg;
    logic [1:0]           kind_filter_reg;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     cursor_reg, cursor_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [LEN_W-1:0]     scan_reg, scan_next;
    logic [FAIL_W-1:0]    fail_reg, fail_next;
    logic                 wrap_reg, wrap_next;
    logic [ID_W-1:0]      res_chosen_reg, res_chosen_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    mem_req_t mem_req;
    entry_t   rd_entry;

    // decoded input word
    cmd_t            cmd;
    logic [ID_W-1:0] in_id;
    logic            in_secure;
    logic            in_plain;
    logic            accept;
    logic            dropped;

    // scan helpers
    logic [IDX_W-1:0]  cur_norm;
    logic [LEN_W-1:0]  scan_inc;
    logic [LEN_W-1:0]  scan_dec;
    logic              scan_last;
    logic              match;
    logic [FAIL_W-1:0] fail_inc;
    logic              wrap_now;
    logic              sink_shift;
    logic              out_free;

    efs_entry_store u_store (
        .aclk     (aclk),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    // input word fields
    assign cmd       = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_id     = s_tdata[CMD_W +: ID_W];
    assign in_secure = s_tuser[0];
    assign in_plain  = s_tuser[1];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign dropped   = (kind_filter_reg[0] && in_secure) || (kind_filter_reg[1] && in_plain);

    // shared compare and count logic
    assign cur_norm   = (LEN_W'(cursor_reg) >= len_reg) ? '0 : cursor_reg;
    assign scan_inc   = scan_reg + LEN_W'(1);
    assign scan_dec   = scan_reg - LEN_W'(1);
    assign scan_last  = (scan_inc >= len_reg);
    assign match      = (rd_entry.id == id_reg);
    assign fail_inc   = rd_entry.fail + FAIL_W'(1);
    assign wrap_now   = (fail_inc == FAIL_LIMIT);
    assign sink_shift = (fail_reg >= rd_entry.fail);
    assign out_free   = !m_tvalid_reg || m_tready;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strategy_reg    <= '0;
            kind_filter_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_STRATEGY) begin
                strategy_reg <= cfg_data;
            end else if (cfg_index == REG_KIND_FILTER) begin
                kind_filter_reg <= cfg_data;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_NEXT: state_next = (len_reg != '0) ? S_NEXT_DATA : S_DONE;
                        CMD_FAIL: state_next = (len_reg > LEN_W'(1)) ? S_SEARCH : S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_NEXT_DATA: state_next = S_DONE;
            S_SEARCH: begin
                if (match) begin
                    if (strategy_reg == STRAT_LEAST && !scan_last) begin
                        state_next = S_SINK;
                    end else begin
                        state_next = wrap_now ? S_HALVE_START : S_DONE;
                    end
                end else if (scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_SINK: begin
                if (sink_shift) begin
                    if (scan_last) begin
                        state_next = S_PLACE;
                    end
                end else begin
                    state_next = wrap_reg ? S_HALVE_START : S_DONE;
                end
            end
            S_PLACE:       state_next = wrap_reg ? S_HALVE_START : S_DONE;
            S_HALVE_START: state_next = S_HALVE;
            S_HALVE: begin
                if (scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory requests and result word
    always_comb begin
        len_next        = len_reg;
        cursor_next     = cursor_reg;
        id_next         = id_reg;
        scan_next       = scan_reg;
        fail_next       = fail_reg;
        wrap_next       = wrap_reg;
        res_chosen_next = res_chosen_reg;
        res_valid_next  = res_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    id_next         = in_id;
                    res_chosen_next = '0;
                    res_valid_next  = 1'b0;
                    scan_next       = '0;
                    unique case (cmd)
                        CMD_CLEAR: begin
                            len_next       = '0;
                            cursor_next    = '0;
                            res_valid_next = 1'b1;
                        end
                        CMD_ADD: begin
                            if (!dropped && len_reg < LEN_W'(MAX_ENTRIES)) begin
                                mem_req.wr_en        = 1'b1;
                                mem_req.wr_addr      = len_reg[IDX_W-1:0];
                                mem_req.wr_data.id   = in_id;
                                mem_req.wr_data.fail = '0;
                                len_next             = len_reg + LEN_W'(1);
                                res_valid_next       = 1'b1;
                            end
                        end
                        CMD_NEXT: begin
                            if (len_reg != '0) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = cur_norm;
                                res_valid_next  = 1'b1;
                                cursor_next     = (strategy_reg >= STRAT_ROUND)
                                                ? cursor_advance(cur_norm, len_reg) : cur_norm;
                            end
                        end
                        CMD_FAIL: begin
                            // start the id search at the head of the list
                            mem_req.rd_en   = (len_reg > LEN_W'(1));
                            mem_req.rd_addr = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_NEXT_DATA: begin
                res_chosen_next = rd_entry.id;
            end
            S_SEARCH: begin
                // read one entry ahead while comparing the current one
                mem_req.rd_en   = !scan_last;
                mem_req.rd_addr = scan_inc[IDX_W-1:0];
                scan_next       = scan_inc;
                if (match) begin
                    res_valid_next = 1'b1;
                    wrap_next      = wrap_now;
                    fail_next      = fail_inc;
                    if (!(strategy_reg == STRAT_LEAST && !scan_last)) begin
                        mem_req.wr_en        = 1'b1;
                        mem_req.wr_addr      = scan_reg[IDX_W-1:0];
                        mem_req.wr_data.id   = id_reg;
                        mem_req.wr_data.fail = fail_inc;
                        if (strategy_reg == STRAT_LAST_OK) begin
                            cursor_next = cursor_advance(cursor_reg, len_reg);
                        end
                    end
                end
            end
            S_SINK: begin
                // move entries with no more failures one slot forward
                mem_req.rd_en   = !scan_last;
                mem_req.rd_addr = scan_inc[IDX_W-1:0];
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = scan_dec[IDX_W-1:0];
                if (sink_shift) begin
                    mem_req.wr_data = rd_entry;
                    scan_next       = scan_inc;
                end else begin
                    mem_req.wr_data.id   = id_reg;
                    mem_req.wr_data.fail = fail_reg;
                end
            end
            S_PLACE: begin
                // failed entry lands at the tail
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = scan_dec[IDX_W-1:0];
                mem_req.wr_data.id   = id_reg;
                mem_req.wr_data.fail = fail_reg;
            end
            S_HALVE_START: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                scan_next       = '0;
            end
            S_HALVE: begin
                // halve the count of each entry in turn
                mem_req.rd_en        = !scan_last;
                mem_req.rd_addr      = scan_inc[IDX_W-1:0];
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = scan_reg[IDX_W-1:0];
                mem_req.wr_data.id   = rd_entry.id;
                mem_req.wr_data.fail = rd_entry.fail >> 1;
                scan_next            = scan_inc;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {M_PAD_W'(0), ENTRIES_W'(len_reg), res_chosen_reg};
                    m_tuser_next  = M_TUSER_W'(res_valid_reg);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            cursor_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cursor_reg   <= cursor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        scan_reg       <= scan_next;
        fail_reg       <= fail_next;
        wrap_reg       <= wrap_next;
        res_chosen_reg <= res_chosen_next;
        res_valid_reg  <= res_valid_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an accepted command always leaves the idle state
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted command did not start work");

    // list length never exceeds capacity
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_ENTRIES))
        else $error("list length beyond capacity");

    // list walks only write inside the current list
    a_walk_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && mem_req.wr_en) |-> (LEN_W'(mem_req.wr_addr) < len_reg))
        else $error("list walk wrote past the list end");

    // result step with a free output slot always delivers a word
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("result not loaded into output register");

endmodule

// ===== tb/sv/efs_selection_checker.sv =====
// selection checker: tracks the endpoint list per command word and compares result words
module efs_selection_checker
    import efs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // command[1:0], entry_id[9:2], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // is_secure[0], is_plain[1]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // chosen_id[7:0], entries_held[12:8], zero pad
    input  logic [M_TUSER_W-1:0]  m_tuser,   // valid_res[0]
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    results_due
);

    // one result word as the list should produce it
    typedef struct packed {
        logic [ID_W-1:0]      chosen;
        logic                 valid;
        logic [ENTRIES_W-1:0] held;
    } sel_result_t;

    // shadow of the endpoint list and both registers
    logic [ID_W-1:0]       ep_id   [MAX_ENTRIES];
    logic [FAIL_W-1:0]     ep_fail [MAX_ENTRIES];
    logic [LEN_W-1:0]      list_len;
    logic [IDX_W-1:0]      sel_cursor;
    logic [1:0]            strat;
    logic [1:0]            filt;
    sel_result_t           due_results[$];

    // cyclic step of the selection cursor
    function automatic logic [IDX_W-1:0] next_cursor();
        logic [LEN_W-1:0] c;
        c = LEN_W'(sel_cursor) + LEN_W'(1);
        return (c >= list_len) ? '0 : c[IDX_W-1:0];
    endfunction

    // apply one command to the shadow list and form its result word
    task automatic run_selector_command(input cmd_t op, input logic [ID_W-1:0] id,
                                        input logic sec, input logic pl,
                                        output sel_result_t res);
        int i;
        int p;
        int k;
        logic hit_limit;
        logic dropped;
        logic [ID_W-1:0] moved_id;
        logic [FAIL_W-1:0] moved_fail;
        res = '0;
        case (op)
            CMD_CLEAR: begin
                list_len = '0;
                sel_cursor = '0;
                res.valid = 1'b1;
            end
            CMD_ADD: begin
                dropped = (filt[0] && sec) || (filt[1] && pl);
                if (!dropped && list_len < MAX_ENTRIES) begin
                    ep_id[list_len[IDX_W-1:0]] = id;
                    ep_fail[list_len[IDX_W-1:0]] = '0;
                    list_len = list_len + 1'b1;
                    res.valid = 1'b1;
                end
            end
            CMD_NEXT: begin
                if (list_len > 0) begin
                    if (LEN_W'(sel_cursor) >= list_len) sel_cursor = '0;
                    res.chosen = ep_id[sel_cursor];
                    res.valid = 1'b1;
                    if (strat >= STRAT_ROUND) sel_cursor = next_cursor();
                end
            end
            default: begin
                if (list_len > 1) begin
                    i = 0;
                    while (i < list_len && ep_id[IDX_W'(i)] != id) i++;
                    if (i < list_len) begin
                        ep_fail[IDX_W'(i)] = ep_fail[IDX_W'(i)] + 1'b1;
                        hit_limit = (ep_fail[IDX_W'(i)] == FAIL_LIMIT);
                        if (strat == STRAT_LAST_OK) begin
                            sel_cursor = next_cursor();
                        end else if (strat == STRAT_LEAST) begin
                            // move the failed entry behind followers with no larger count
                            p = i + 1;
                            while (p < list_len && ep_fail[IDX_W'(i)] >= ep_fail[IDX_W'(p)]) p++;
                            if (p != i + 1) begin
                                moved_id = ep_id[IDX_W'(i)];
                                moved_fail = ep_fail[IDX_W'(i)];
                                for (k = i; k + 1 < p; k++) begin
                                    ep_id[IDX_W'(k)] = ep_id[IDX_W'(k + 1)];
                                    ep_fail[IDX_W'(k)] = ep_fail[IDX_W'(k + 1)];
                                end
                                ep_id[IDX_W'(p - 1)] = moved_id;
                                ep_fail[IDX_W'(p - 1)] = moved_fail;
                            end
                        end
                        // a saturated count halves every count in the list
                        if (hit_limit) begin
                            for (k = 0; k < list_len; k++)
                                ep_fail[IDX_W'(k)] = ep_fail[IDX_W'(k)] >> 1;
                        end
                        res.valid = 1'b1;
                    end
                end
            end
        endcase
        res.held = ENTRIES_W'(list_len);
    endtask

    // result words are compared before new command words are queued
    always @(posedge aclk) begin
        sel_result_t got;
        sel_result_t want;
        if (!aresetn) begin
            list_len = '0;
            sel_cursor = '0;
            strat = '0;
            filt = '0;
            mismatch_count = 0;
            due_results.delete();
        end else begin
            // compare each result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.chosen = m_tdata[ID_W-1:0];
                got.held = m_tdata[ID_W +: ENTRIES_W];
                got.valid = m_tuser[0];
                if (due_results.size() == 0) begin
                    $error("result word with no command outstanding: chosen_id %0h", got.chosen);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.chosen !== want.chosen) begin
                        $error("chosen_id mismatch: expected %0h, got %0h",
                               want.chosen, got.chosen);
                        mismatch_count++;
                    end
                    if (got.valid !== want.valid) begin
                        $error("valid_res mismatch: expected %0d, got %0d",
                               want.valid, got.valid);
                        mismatch_count++;
                    end
                    if (got.held !== want.held) begin
                        $error("entries_held mismatch: expected %0d, got %0d",
                               want.held, got.held);
                        mismatch_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:ID_W+ENTRIES_W] !== '0) begin
                        $error("m_tdata pad mismatch: expected 0, got %0h",
                               m_tdata[M_TDATA_W-1:ID_W+ENTRIES_W]);
                        mismatch_count++;
                    end
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_STRATEGY) strat = cfg_data;
                else if (cfg_index == REG_KIND_FILTER) filt = cfg_data;
            end
            // predict the word for each accepted command
            if (s_tvalid && s_tready) begin
                run_selector_command(cmd_t'(s_tdata[CMD_W-1:0]), s_tdata[CMD_W +: ID_W],
                                     s_tuser[0], s_tuser[1], want);
                due_results.push_back(want);
            end
        end
        results_due = due_results.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: command stimulus, receiver stalls, register phases and verdict
module tb_top;
    import efs_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 75;

    // strategy three is an alias of round robin
    localparam logic [1:0] STRAT_ROUND_ALIAS = 2'd3;
    // kind filter settings
    localparam logic [1:0] FILTER_NONE   = 2'd0;
    localparam logic [1:0] FILTER_SECURE = 2'd1;
    localparam logic [1:0] FILTER_PLAIN  = 2'd2;
    localparam logic [1:0] FILTER_BOTH   = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int              mismatch_count;
    int              results_due;
    int              cycle_count = 0;
    int              send_calm = 0;
    int              recv_calm = 0;
    logic [ID_W-1:0] id_pool[$];

    logic [1:0] strat_plan [8] = '{STRAT_LAST_OK, STRAT_LEAST, STRAT_ROUND, STRAT_ROUND_ALIAS,
                                   STRAT_LEAST, STRAT_LAST_OK, STRAT_ROUND, STRAT_LEAST};
    logic [1:0] filt_plan  [8] = '{FILTER_NONE, FILTER_NONE, FILTER_NONE, FILTER_NONE,
                                   FILTER_SECURE, FILTER_PLAIN, FILTER_BOTH, FILTER_NONE};

    endpoint_failover_selector_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    efs_selection_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls per word with occasional stall-free stretches
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (recv_calm > 0) recv_calm--;
            else if ($urandom_range(0, 19) == 0) recv_calm = 20;
            stall = (recv_calm > 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // send one command word after a random gap
    task automatic send_cmd(input cmd_t op, input logic [ID_W-1:0] id,
                            input logic sec, input logic pl);
        int gap;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 19) == 0) send_calm = 20;
        gap = (send_calm > 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - CMD_W - ID_W){1'b0}}, id, op};
        s_tuser <= {pl, sec};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // let every outstanding result word drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    // register write, only issued while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // random command mix, failures mostly aimed at listed endpoints
    task automatic random_commands(input int count);
        int roll;
        logic [ID_W-1:0] id;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            id = ID_W'($urandom_range(0, 255));
            if (roll < 3) begin
                id_pool.delete();
                send_cmd(CMD_CLEAR, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (roll < 35) begin
                if (id_pool.size() > 0 && $urandom_range(0, 4) == 0)
                    id = id_pool[$urandom_range(0, id_pool.size() - 1)];
                id_pool.push_back(id);
                send_cmd(CMD_ADD, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (roll < 62) begin
                send_cmd(CMD_NEXT, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if (id_pool.size() > 0 && $urandom_range(0, 3) != 0)
                    id = id_pool[$urandom_range(0, id_pool.size() - 1)];
                send_cmd(CMD_FAIL, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // main stimulus and verdict
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, single entry, duplicates, unknown ids
        send_cmd(CMD_NEXT, 8'hFF, 1'b1, 1'b1);
        send_cmd(CMD_FAIL, 8'hAA, 1'b0, 1'b0);
        send_cmd(CMD_ADD,  8'hFF, 1'b1, 1'b1);
        send_cmd(CMD_FAIL, 8'hFF, 1'b0, 1'b0);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);
        send_cmd(CMD_ADD,  8'h00, 1'b0, 1'b0);
        send_cmd(CMD_ADD,  8'hFF, 1'b0, 1'b1);
        send_cmd(CMD_FAIL, 8'h7E, 1'b1, 1'b0);
        send_cmd(CMD_FAIL, 8'hFF, 1'b0, 1'b0);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);
        // directed: kind filter settings
        write_reg(REG_KIND_FILTER, FILTER_SECURE);
        send_cmd(CMD_ADD,  8'h01, 1'b1, 1'b0);
        send_cmd(CMD_ADD,  8'h02, 1'b0, 1'b1);
        write_reg(REG_KIND_FILTER, FILTER_PLAIN);
        send_cmd(CMD_ADD,  8'h03, 1'b0, 1'b1);
        send_cmd(CMD_ADD,  8'h04, 1'b1, 1'b0);
        write_reg(REG_KIND_FILTER, FILTER_BOTH);
        send_cmd(CMD_ADD,  8'h05, 1'b0, 1'b0);
        // directed: least-failures, round robin and its alias reacting to next and failure
        write_reg(REG_KIND_FILTER, FILTER_NONE);
        write_reg(REG_STRATEGY, STRAT_LEAST);
        send_cmd(CMD_FAIL, 8'hFF, 1'b0, 1'b0);
        send_cmd(CMD_FAIL, 8'h02, 1'b0, 1'b0);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);
        write_reg(REG_STRATEGY, STRAT_ROUND);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);
        send_cmd(CMD_FAIL, 8'h00, 1'b0, 1'b0);
        write_reg(REG_STRATEGY, STRAT_ROUND_ALIAS);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);
        send_cmd(CMD_FAIL, 8'h04, 1'b0, 1'b0);
        send_cmd(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
        send_cmd(CMD_NEXT, 8'h00, 1'b0, 1'b0);

        // random phases across strategy and filter settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_STRATEGY, strat_plan[ph]);
            write_reg(REG_KIND_FILTER, filt_plan[ph]);
            random_commands(PHASE_ITEMS);
        end

        // drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
